[hdl/aete_pkg.sv]
// aete_pkg: shared codes and types of the animation effect timing evaluator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package aete_pkg;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_BEFORE = 2'd1;
  localparam logic [1:0] PH_ACTIVE = 2'd2;
  localparam logic [1:0] PH_AFTER  = 2'd3;

  // fill modes
  localparam logic [1:0] FILL_NONE      = 2'd0;
  localparam logic [1:0] FILL_FORWARDS  = 2'd1;
  localparam logic [1:0] FILL_BACKWARDS = 2'd2;
  localparam logic [1:0] FILL_BOTH      = 2'd3;

  // playback directions
  localparam logic [1:0] DIR_NORMAL    = 2'd0;
  localparam logic [1:0] DIR_REVERSE   = 2'd1;
  localparam logic [1:0] DIR_ALT       = 2'd2;
  localparam logic [1:0] DIR_ALT_REV   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_START_DELAY = 3'd0;
  localparam logic [2:0] REG_END_DELAY   = 3'd1;
  localparam logic [2:0] REG_DURATION    = 3'd2;
  localparam logic [2:0] REG_COUNT       = 3'd3;
  localparam logic [2:0] REG_ITER_START  = 3'd4;
  localparam logic [2:0] REG_FILL        = 3'd5;
  localparam logic [2:0] REG_DIRECTION   = 3'd6;

  localparam logic [31:0] COUNT_INF   = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_RESET = 32'h0001_0000;
  localparam int          CALC_CYCLES = 8;

  // control that travels beside an item
  typedef struct packed {
    logic       vld;
    logic       act_vld;
    logic       pre;
    logic       after;
    logic [1:0] phase;
  } side_t;

endpackage
`default_nettype wire

[hdl/aete_cfg.sv]
// aete_cfg: register file on the apb-style port and the derived timing values
// depends on aete_pkg; feeds aete_front, aete_div and aete_back
`timescale 1ns / 1ps
`default_nettype none
module aete_cfg #(
  parameter int TW = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [5:0]           paddr,
  input  wire logic [63:0]          pwdata,
  output logic      [63:0]          prdata,
  output logic                      pready,
  output logic                      busy,
  output logic        [TW-2:0]      dur,
  output logic        [31:0]        count,
  output logic        [31:0]        istart,
  output logic        [1:0]         fill,
  output logic        [1:0]         dir,
  output logic        [TW-2:0]      ad,
  output logic                      ad_inf,
  output logic signed [TW-1:0]      nsd,
  output logic signed [TW-1:0]      bb,
  output logic signed [TW-1:0]      ab
);
  import aete_pkg::*;

  localparam int DW = TW - 1;
  localparam logic signed [TW-1:0] MAXT = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] MINT = {1'b1, {(TW-1){1'b0}}};
  localparam logic [DW-1:0] MAXU = {DW{1'b1}};

  logic signed [TW-1:0] start_r, end_r;
  logic [DW-1:0] dur_r;
  logic [31:0]   count_r, istart_r;
  logic [1:0]    fill_r, dir_r;
  logic [3:0]    calc_r, calc_nxt;

  logic          wr;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      dur_r    <= '0;
      count_r  <= COUNT_RESET;
      istart_r <= '0;
      fill_r   <= FILL_NONE;
      dir_r    <= DIR_NORMAL;
    end else if (wr) begin
      case (idx)
        REG_START_DELAY: start_r  <= pwdata[TW-1:0];
        REG_END_DELAY:   end_r    <= pwdata[TW-1:0];
        REG_DURATION:    dur_r    <= pwdata[DW-1:0];
        REG_COUNT:       count_r  <= pwdata[31:0];
        REG_ITER_START:  istart_r <= pwdata[31:0];
        REG_FILL:        fill_r   <= pwdata[1:0];
        REG_DIRECTION:   dir_r    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_DELAY: prdata = 64'($signed(start_r));
      REG_END_DELAY:   prdata = 64'($signed(end_r));
      REG_DURATION:    prdata = 64'(dur_r);
      REG_COUNT:       prdata = 64'(count_r);
      REG_ITER_START:  prdata = 64'(istart_r);
      REG_FILL:        prdata = 64'(fill_r);
      REG_DIRECTION:   prdata = 64'(dir_r);
      default:         prdata = '0;
    endcase
  end

  // busy counts down after reset and after any write while the derived values settle
  always_comb begin
    calc_nxt = calc_r;
    if (wr) calc_nxt = 4'(CALC_CYCLES);
    else if (calc_r != '0) calc_nxt = calc_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) calc_r <= 4'(CALC_CYCLES);
    else calc_r <= calc_nxt;
  end

  assign busy = (calc_r != '0);

  // active duration: partial products, then the sum with saturation
  logic [DW+15:0] hi_r;
  logic [DW-1:0]  lo1_r, hi_lo_r;
  logic [31:0]    lo2_r;
  logic [DW:0]    lo_r;
  logic           hi_over_r;
  logic [DW+1:0]  ad_sum;
  logic [DW-1:0]  ad_r;
  logic           ad_inf_r;
  logic           d_zero, c_inf;

  assign d_zero = (dur_r == '0) || (count_r == '0);
  assign c_inf  = (count_r == COUNT_INF);
  assign ad_sum = (DW+2)'(hi_lo_r) + (DW+2)'(lo_r);

  always_ff @(posedge clk) begin
    hi_r      <= dur_r * count_r[31:16];
    lo1_r     <= dur_r[DW-1:16] * count_r[15:0];
    lo2_r     <= dur_r[15:0] * count_r[15:0];
    lo_r      <= (DW+1)'(lo1_r) + (DW+1)'(lo2_r[31:16]);
    hi_over_r <= (hi_r > (DW+16)'(MAXU));
    hi_lo_r   <= hi_r[DW-1:0];
    ad_inf_r  <= c_inf && (dur_r != '0);
    if (d_zero) ad_r <= '0;
    else if (c_inf || hi_over_r || (ad_sum[DW+1:DW] != 2'b00)) ad_r <= MAXU;
    else ad_r <= ad_sum[DW-1:0];
  end

  // boundaries: start + ad, end time, before and after boundaries
  logic signed [TW:0]   s1_sum, et_sum;
  logic signed [TW-1:0] s1_r, et_r, nsd_r, bb_r, ab_r;
  logic signed [TW-1:0] s1_sat, et_sat, bmin, amin;

  assign s1_sum = {start_r[TW-1], start_r} + {2'b00, ad_r};
  assign s1_sat = (s1_sum[TW] != s1_sum[TW-1]) ? (s1_sum[TW] ? MINT : MAXT) : s1_sum[TW-1:0];
  assign et_sum = {s1_r[TW-1], s1_r} + {end_r[TW-1], end_r};
  assign et_sat = (et_sum[TW] != et_sum[TW-1]) ? (et_sum[TW] ? MINT : MAXT) : et_sum[TW-1:0];
  assign bmin   = ad_inf_r ? start_r : ((start_r < et_r) ? start_r : et_r);
  assign amin   = (s1_r < et_r) ? s1_r : et_r;

  always_ff @(posedge clk) begin
    s1_r  <= s1_sat;
    nsd_r <= (start_r == MINT) ? MAXT : -start_r;
    et_r  <= (et_sat < 0) ? '0 : et_sat;
    bb_r  <= (bmin < 0) ? '0 : bmin;
    ab_r  <= (amin < 0) ? '0 : amin;
  end

  assign dur    = dur_r;
  assign count  = count_r;
  assign istart = istart_r;
  assign fill   = fill_r;
  assign dir    = dir_r;
  assign ad     = ad_r;
  assign ad_inf = ad_inf_r;
  assign nsd    = nsd_r;
  assign bb     = bb_r;
  assign ab     = ab_r;

endmodule
`default_nettype wire

[hdl/aete_front.sv]
// aete_front: input register, phase decision and active time (three stages)
// depends on aete_pkg; driven by aete_cfg, feeds aete_div
`timescale 1ns / 1ps
`default_nettype none
module aete_front #(
  parameter int TW = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire logic signed [TW-1:0] lt,
  input  wire logic                 resolved,
  input  wire logic                 neg,
  input  wire logic [1:0]           fill,
  input  wire logic [TW-2:0]        ad,
  input  wire logic                 ad_inf,
  input  wire logic signed [TW-1:0] nsd,
  input  wire logic signed [TW-1:0] bb,
  input  wire logic signed [TW-1:0] ab,
  output aete_pkg::side_t           side_o,
  output logic [TW-2:0]             at_o
);
  import aete_pkg::*;

  localparam int DW = TW - 1;
  localparam logic signed [TW-1:0] MAXT = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] MINT = {1'b1, {(TW-1){1'b0}}};

  // stage a
  logic                 a_vld_r, a_res_r, a_neg_r;
  logic signed [TW-1:0] a_lt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= acc;
    a_lt_r  <= lt;
    a_res_r <= resolved;
    a_neg_r <= neg;
  end

  // stage b
  logic                 is_before, is_after;
  logic signed [TW:0]   d_sum;
  logic signed [TW-1:0] d_sat;
  side_t                b_side_r, b_side_nxt;
  logic signed [TW-1:0] b_diff_r;

  assign is_before = (a_lt_r < bb) || (a_neg_r && (a_lt_r == bb));
  assign is_after  = !is_before && !ad_inf &&
                     ((a_lt_r > ab) || (!a_neg_r && (a_lt_r == ab)));
  assign d_sum = {a_lt_r[TW-1], a_lt_r} + {nsd[TW-1], nsd};
  assign d_sat = (d_sum[TW] != d_sum[TW-1]) ? (d_sum[TW] ? MINT : MAXT) : d_sum[TW-1:0];

  always_comb begin
    b_side_nxt.vld     = a_vld_r;
    b_side_nxt.act_vld = 1'b0;
    b_side_nxt.pre     = a_res_r && is_before;
    b_side_nxt.after   = a_res_r && is_after;
    if (!a_res_r) b_side_nxt.phase = PH_IDLE;
    else if (is_before) b_side_nxt.phase = PH_BEFORE;
    else if (is_after) b_side_nxt.phase = PH_AFTER;
    else b_side_nxt.phase = PH_ACTIVE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_side_r <= '0;
    else b_side_r <= b_side_nxt;
    b_diff_r <= d_sat;
  end

  // stage c
  side_t                c_side_r, c_side_nxt;
  logic [DW-1:0]        c_at_r, c_at_nxt;
  logic signed [TW-1:0] clip;

  assign clip = (b_diff_r > $signed({1'b0, ad})) ? $signed({1'b0, ad}) : b_diff_r;

  always_comb begin
    c_side_nxt = b_side_r;
    c_at_nxt   = '0;
    case (b_side_r.phase)
      PH_BEFORE: c_side_nxt.act_vld = (fill == FILL_BACKWARDS) || (fill == FILL_BOTH);
      PH_AFTER:  c_side_nxt.act_vld = (fill == FILL_FORWARDS) || (fill == FILL_BOTH);
      PH_ACTIVE: c_side_nxt.act_vld = 1'b1;
      default:   c_side_nxt.act_vld = 1'b0;
    endcase
    if (c_side_nxt.act_vld) begin
      if (b_side_r.after) c_at_nxt = (clip < 0) ? '0 : clip[DW-1:0];
      else c_at_nxt = (b_diff_r < 0) ? '0 : b_diff_r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_side_r <= '0;
    else c_side_r <= c_side_nxt;
    c_at_r <= c_at_nxt;
  end

  assign side_o = c_side_r;
  assign at_o   = c_at_r;

endmodule
`default_nettype wire

[hdl/aete_div.sv]
// aete_div: pipelined restoring divider, one quotient bit per stage
// depends on aete_pkg; takes active time from aete_front, feeds aete_back
`timescale 1ns / 1ps
`default_nettype none
module aete_div #(
  parameter int TW = 48,
  parameter int PF = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire aete_pkg::side_t              side_i,
  input  wire logic [TW-2:0]                at_i,
  input  wire logic [TW-2:0]                dur,
  output aete_pkg::side_t                   side_o,
  output logic [TW-2:0]                     at_o,
  output logic [TW+PF-2:0]                  quo_o
);
  import aete_pkg::*;

  localparam int DW = TW - 1;
  localparam int QW = DW + PF;

  side_t         side_r [1:QW];
  logic [DW-1:0] at_r   [1:QW];
  logic [DW-1:0] rem_r  [1:QW];
  logic [DW-1:0] num_r  [1:QW];
  logic [QW-1:0] quo_r  [1:QW];

  for (genvar gi = 1; gi <= QW; gi++) begin : g_st
    side_t         s_side;
    logic [DW-1:0] s_at, s_rem, s_num;
    logic [QW-1:0] s_quo;
    logic [DW:0]   trial;
    logic          fits;

    if (gi == 1) begin : g_first
      assign s_side = side_i;
      assign s_at   = at_i;
      assign s_rem  = '0;
      assign s_num  = at_i;
      assign s_quo  = '0;
    end else begin : g_next
      assign s_side = side_r[gi-1];
      assign s_at   = at_r[gi-1];
      assign s_rem  = rem_r[gi-1];
      assign s_num  = num_r[gi-1];
      assign s_quo  = quo_r[gi-1];
    end

    // dividend bits run out after DW stages, then zeros form the fraction
    assign trial = {s_rem, s_num[DW-1]};
    assign fits  = (trial >= {1'b0, dur});

    always_ff @(posedge clk) begin
      if (!rst_n) side_r[gi] <= '0;
      else side_r[gi] <= s_side;
      at_r[gi]  <= s_at;
      num_r[gi] <= {s_num[DW-2:0], 1'b0};
      rem_r[gi] <= fits ? DW'(trial - {1'b0, dur}) : trial[DW-1:0];
      quo_r[gi] <= {s_quo[QW-2:0], fits};
    end
  end

  assign side_o = side_r[QW];
  assign at_o   = at_r[QW];
  assign quo_o  = quo_r[QW];

endmodule
`default_nettype wire

[hdl/aete_back.sv]
// aete_back: overall progress, simple progress, iteration and direction (three stages)
// depends on aete_pkg; takes the divider output and settings from aete_cfg
`timescale 1ns / 1ps
`default_nettype none
module aete_back #(
  parameter int TW = 48,
  parameter int PF = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire aete_pkg::side_t      side_i,
  input  wire logic [TW-2:0]        at_i,
  input  wire logic [TW+PF-2:0]     quo_i,
  input  wire logic [TW-2:0]        dur,
  input  wire logic [31:0]          count,
  input  wire logic [31:0]          istart,
  input  wire logic [1:0]           dir,
  input  wire logic [TW-2:0]        ad,
  input  wire logic                 ad_inf,
  output logic                      out_valid,
  output logic [1:0]                out_phase_code,
  output logic                      out_active_valid,
  output logic [TW-2:0]             out_act_time,
  output logic [PF:0]               out_simple_progress,
  output logic [PF:0]               out_dir_progress,
  output logic [31:0]               out_iteration_index,
  output logic                      out_iteration_infinite,
  output logic                      out_forward,
  output logic                      out_ease_flag
);
  import aete_pkg::*;

  localparam int DW  = TW - 1;
  localparam int PFW = PF + 1;
  localparam logic [PF:0] PONE = {1'b1, {PF{1'b0}}};

  logic [PF:0] q_start, q_count;

  if (PF >= 16) begin : g_wide
    assign q_start = PFW'(istart[15:0]) << (PF - 16);
    assign q_count = PFW'(count[15:0]) << (PF - 16);
  end else begin : g_narrow
    assign q_start = PFW'(istart[15:0] >> (16 - PF));
    assign q_count = PFW'(count[15:0] >> (16 - PF));
  end

  logic d_zero, c_inf;
  assign d_zero = (dur == '0);
  assign c_inf  = (count == COUNT_INF);

  // stage 1: add the iteration start
  logic [TW-1:0] ip0;
  logic [PF:0]   fr0, fr_sum;
  logic          ov_inf;

  side_t         f1_side_r;
  logic [DW-1:0] f1_at_r;
  logic [TW-1:0] f1_ip_r;
  logic [PF-1:0] f1_fr_r;
  logic          f1_ov_r;

  always_comb begin
    ov_inf = d_zero && !side_i.pre && c_inf;
    if (!d_zero) begin
      ip0 = TW'(quo_i[TW+PF-2:PF]);
      fr0 = PFW'(quo_i[PF-1:0]);
    end else if (side_i.pre || c_inf) begin
      ip0 = '0;
      fr0 = '0;
    end else begin
      ip0 = TW'(count[31:16]);
      fr0 = q_count;
    end
    fr_sum = fr0 + q_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f1_side_r <= '0;
    else f1_side_r <= side_i;
    f1_at_r <= at_i;
    f1_ip_r <= ip0 + TW'(istart[31:16]) + TW'(fr_sum[PF]);
    f1_fr_r <= fr_sum[PF-1:0];
    f1_ov_r <= ov_inf;
  end

  // stage 2: simple progress and the end-of-iteration case
  logic [PF:0]   simple;
  side_t         f2_side_r;
  logic [DW-1:0] f2_at_r;
  logic [TW-1:0] f2_ip_r;
  logic [PF:0]   f2_simple_r;
  logic          f2_it_inf_r, f2_dec_r;

  always_comb begin
    simple = f1_ov_r ? q_start : {1'b0, f1_fr_r};
    // at the very end of the active interval progress reads one, not zero
    if ((simple == '0) && !f1_side_r.pre && !ad_inf && (f1_at_r == ad) && (count != '0))
      simple = PONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f2_side_r <= '0;
    else f2_side_r <= f1_side_r;
    f2_at_r     <= f1_at_r;
    f2_ip_r     <= f1_ip_r;
    f2_simple_r <= simple;
    f2_it_inf_r <= f1_side_r.after && c_inf;
    f2_dec_r    <= (simple == PONE);
  end

  // stage 3: current iteration, direction, output register
  logic [TW-1:0] base;
  logic          fwd;
  logic [31:0]   iter;

  always_comb begin
    if (f2_it_inf_r) base = '1;
    else if (f2_dec_r && (f2_ip_r != '0)) base = f2_ip_r - TW'(1);
    else base = f2_ip_r;
    case (dir)
      DIR_NORMAL:  fwd = 1'b1;
      DIR_REVERSE: fwd = 1'b0;
      DIR_ALT:     fwd = f2_it_inf_r || !base[0];
      DIR_ALT_REV: fwd = f2_it_inf_r || base[0];
      default:     fwd = 1'b1;
    endcase
    if (f2_it_inf_r || ((base >> 32) != '0)) iter = 32'hFFFF_FFFF;
    else iter = base[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= f2_side_r.vld;
    out_phase_code <= f2_side_r.phase;
    if (f2_side_r.act_vld) begin
      out_active_valid       <= 1'b1;
      out_act_time           <= f2_at_r;
      out_simple_progress    <= f2_simple_r;
      out_dir_progress       <= fwd ? f2_simple_r : PONE - f2_simple_r;
      out_iteration_index    <= iter;
      out_iteration_infinite <= f2_it_inf_r;
      out_forward            <= fwd;
      out_ease_flag          <= (f2_side_r.pre && fwd) || (f2_side_r.after && !fwd);
    end else begin
      out_active_valid       <= 1'b0;
      out_act_time           <= '0;
      out_simple_progress    <= '0;
      out_dir_progress       <= '0;
      out_iteration_index    <= '0;
      out_iteration_infinite <= 1'b0;
      out_forward            <= 1'b0;
      out_ease_flag          <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/animation_effect_timing_evaluator.sv]
// channel    | ports                              | beat marked by
// -----------+------------------------------------+------------------------------
// input      | in_local_time, in_local_time_resolved, in_rate_negative | start & !busy
// result     | out_* (nine fields)                | out_valid, one cycle, no stall
// config     | psel penable pwrite paddr pwdata prdata pready | psel&penable&pwrite
//
// one item per cycle while busy is low; an item passes through aete_front, the
// one-bit-per-stage quotient pipeline of aete_div and then aete_back
// after reset and after every register write busy stays high while the active
// duration and phase boundaries are recomputed
// results cannot be held off, so the pipeline never stalls
// top level: ties together aete_cfg, aete_front, aete_div and aete_back
`timescale 1ns / 1ps
`default_nettype none
module animation_effect_timing_evaluator #(
  parameter int TIME_WIDTH         = 48,
  parameter int PROGRESS_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [TIME_WIDTH-1:0]  in_local_time,
  input  wire logic                          in_local_time_resolved,
  input  wire logic                          in_rate_negative,
  output logic                               out_valid,
  output logic [1:0]                         out_phase_code,
  output logic                               out_active_valid,
  output logic [TIME_WIDTH-2:0]              out_act_time,
  output logic [PROGRESS_FRAC_BITS:0]        out_simple_progress,
  output logic [PROGRESS_FRAC_BITS:0]        out_dir_progress,
  output logic [31:0]                        out_iteration_index,
  output logic                               out_iteration_infinite,
  output logic                               out_forward,
  output logic                               out_ease_flag,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [5:0]                    paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  import aete_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int PF = PROGRESS_FRAC_BITS;

  logic [TW-2:0]        dur, ad, fr_at, dv_at;
  logic [31:0]          count, istart;
  logic [1:0]           fill, dir;
  logic                 ad_inf;
  logic signed [TW-1:0] nsd, bb, ab;
  side_t                fr_side, dv_side;
  logic [TW+PF-2:0]     quo;

  aete_cfg #(.TW(TW)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .busy, .dur, .count, .istart, .fill, .dir, .ad, .ad_inf, .nsd, .bb, .ab
  );

  aete_front #(.TW(TW)) u_front (
    .clk, .rst_n,
    .acc      (start & ~busy),
    .lt       (in_local_time),
    .resolved (in_local_time_resolved),
    .neg      (in_rate_negative),
    .fill, .ad, .ad_inf, .nsd, .bb, .ab,
    .side_o   (fr_side),
    .at_o     (fr_at)
  );

  aete_div #(.TW(TW), .PF(PF)) u_div (
    .clk, .rst_n,
    .side_i (fr_side),
    .at_i   (fr_at),
    .dur,
    .side_o (dv_side),
    .at_o   (dv_at),
    .quo_o  (quo)
  );

  aete_back #(.TW(TW), .PF(PF)) u_back (
    .clk, .rst_n,
    .side_i (dv_side),
    .at_i   (dv_at),
    .quo_i  (quo),
    .dur, .count, .istart, .dir, .ad, .ad_inf,
    .out_valid, .out_phase_code, .out_active_valid, .out_act_time,
    .out_simple_progress, .out_dir_progress, .out_iteration_index,
    .out_iteration_infinite, .out_forward, .out_ease_flag
  );

endmodule
`default_nettype wire
